[src/cba_pkg.sv]
// Package for the first-fit contiguous block allocator.
// Holds sizes, status and command codes, and the request/result/command types.
// No dependencies.
package cba_pkg;

  localparam int HEAP_BYTES = 1024;
  localparam int UNIT_BYTES = 8;
  localparam int NUM_UNITS  = HEAP_BYTES / UNIT_BYTES;
  localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
  localparam int UNIT_W     = $clog2(NUM_UNITS);
  localparam int CNT_W      = $clog2(NUM_UNITS + 1);
  localparam int SIZE_W     = 11;
  localparam int ADDR_W     = 10;
  localparam int STAT_W     = 3;
  localparam int ID_W       = 16;

  localparam logic [ID_W-1:0] ID_MAX = '1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_FULL     = 3'd2,
    ST_NO_RUN   = 3'd3,
    ST_BAD_FREE = 3'd4
  } cba_status_t;

  typedef enum logic [1:0] {
    K_ALLOC    = 2'd0,
    K_FREE     = 2'd1,
    K_BAD_SIZE = 2'd2,
    K_BAD_FREE = 2'd3
  } cba_kind_t;

  typedef struct packed {
    logic              cmd;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] offset;
  } cba_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  free_units;
  } cba_out_t;

  typedef struct packed {
    cba_kind_t         kind;
    logic [CNT_W-1:0]  need;
    logic [UNIT_W-1:0] unit;
  } cba_cmd_t;

endpackage

[src/cba_front.sv]
// Front end: takes requests, checks size and offset, converts to unit terms,
// and holds them in a two-entry command queue for the back end. Uses cba_pkg.
module cba_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  cba_pkg::cba_in_t  in_req,
  output logic              cq_valid,
  output cba_pkg::cba_cmd_t cq_head,
  input  logic              cq_pop
);
  import cba_pkg::*;

  cba_cmd_t          q_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              push;
  cba_cmd_t          cls;
  logic              size_ok;
  logic [SIZE_W:0]   need_sum;
  logic [SIZE_W-1:0] size_m1;

  // heap size is a power of two: a divisor is any power of two up to it
  assign size_m1  = in_req.size_bytes - SIZE_W'(1);
  assign size_ok  = (in_req.size_bytes != '0) && ((in_req.size_bytes & size_m1) == '0) &&
                    (in_req.size_bytes <= SIZE_W'(HEAP_BYTES));
  assign need_sum = {1'b0, in_req.size_bytes} + (SIZE_W+1)'(UNIT_BYTES - 1);

  always_comb begin
    cls.need = need_sum[UNIT_SHIFT +: CNT_W];
    cls.unit = in_req.offset[UNIT_SHIFT +: UNIT_W];
    if (in_req.cmd == CMD_ALLOC) begin
      cls.kind = size_ok ? K_ALLOC : K_BAD_SIZE;
    end else begin
      cls.kind = ({1'b0, in_req.offset} >= (ADDR_W+1)'(HEAP_BYTES)) ? K_BAD_FREE : K_FREE;
    end
  end

  assign in_full  = (cnt_r == 2'd2);
  assign push     = in_push && !in_full;
  assign cq_valid = (cnt_r != 2'd0);
  assign cq_head  = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(cq_pop && cq_valid)) cnt_nxt = cnt_r + 2'd1;
    else if (!push && cq_pop && cq_valid) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cls;
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (cq_pop && cq_valid) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[src/cba_back.sv]
// Back end: owner table, first-fit scan, run marking and free sweep, plus a
// two-entry result queue. Takes commands from cba_front. Uses cba_pkg.
module cba_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cq_valid,
  input  cba_pkg::cba_cmd_t cq_head,
  output logic              cq_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output cba_pkg::cba_out_t out_res
);
  import cba_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_MARK  = 6'b000100,
    S_FID   = 6'b001000,
    S_SWEEP = 6'b010000,
    S_RES   = 6'b100000
  } state_t;

  state_t            state_r;
  cba_cmd_t          cur_r;
  logic [ID_W-1:0]   owner_mem [NUM_UNITS];
  logic [ID_W-1:0]   rd_data_r;
  logic [NUM_UNITS-1:0] busy_r;
  logic [ID_W-1:0]   next_id_r, id_r;
  logic [CNT_W-1:0]  free_count_r, run_r, left_r, run_inc;
  logic [UNIT_W-1:0] idx_r, start_r, chk_idx_r, start_calc;
  logic              chk_vld_r, iss_done_r;
  logic [ADDR_W-1:0] addr_r;
  cba_status_t       status_r;
  logic              mem_we, mem_re;
  logic [UNIT_W-1:0] mem_ra;
  logic              hit;

  cba_out_t          rq_r [2];
  logic              rq_wr_r, rq_rd_r;
  logic [1:0]        rq_cnt_r;
  logic              rq_push, rq_full;

  assign rq_full   = (rq_cnt_r == 2'd2);
  assign out_empty = (rq_cnt_r == 2'd0);
  assign out_res   = rq_r[rq_rd_r];
  assign rq_push   = (state_r == S_RES) && !rq_full;
  assign cq_pop    = (state_r == S_IDLE) && cq_valid;

  assign run_inc    = run_r + CNT_W'(1);
  assign start_calc = UNIT_W'(({1'b0, idx_r} + CNT_W'(1)) - cur_r.need);
  assign hit        = (state_r == S_SWEEP) && chk_vld_r && busy_r[chk_idx_r] &&
                      (rd_data_r == id_r);

  always_comb begin
    mem_we = (state_r == S_MARK);
    mem_re = 1'b0;
    mem_ra = idx_r;
    if (cq_pop && cq_head.kind == K_FREE) begin
      mem_re = 1'b1;
      mem_ra = cq_head.unit;
    end else if (state_r == S_SWEEP && !iss_done_r) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) owner_mem[start_r] <= next_id_r;
    if (mem_re) rd_data_r <= owner_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rq_push) rq_r[rq_wr_r] <= '{address: addr_r, status: status_r,
                                    free_units: free_count_r};
    if (!rst_n) begin
      rq_wr_r  <= 1'b0;
      rq_rd_r  <= 1'b0;
      rq_cnt_r <= 2'd0;
    end else begin
      if (rq_push) rq_wr_r <= ~rq_wr_r;
      if (out_pop && !out_empty) rq_rd_r <= ~rq_rd_r;
      if (rq_push && !(out_pop && !out_empty)) rq_cnt_r <= rq_cnt_r + 2'd1;
      else if (!rq_push && out_pop && !out_empty) rq_cnt_r <= rq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      busy_r       <= '0;
      next_id_r    <= ID_W'(1);
      free_count_r <= CNT_W'(NUM_UNITS);
      chk_vld_r    <= 1'b0;
      iss_done_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cq_valid) begin
            cur_r  <= cq_head;
            addr_r <= '0;
            idx_r  <= '0;
            run_r  <= '0;
            unique case (cq_head.kind)
              K_BAD_SIZE: begin
                status_r <= ST_BAD_SIZE;
                state_r  <= S_RES;
              end
              K_BAD_FREE: begin
                status_r <= ST_BAD_FREE;
                state_r  <= S_RES;
              end
              K_ALLOC: begin
                if (free_count_r == '0) begin
                  status_r <= ST_FULL;
                  state_r  <= S_RES;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              K_FREE: begin
                if (!busy_r[cq_head.unit]) begin
                  status_r <= ST_BAD_FREE;
                  state_r  <= S_RES;
                end else begin
                  state_r <= S_FID;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          idx_r <= idx_r + UNIT_W'(1);
          if (!busy_r[idx_r]) begin
            run_r <= run_inc;
            if (run_inc == cur_r.need) begin
              start_r <= start_calc;
              addr_r  <= ADDR_W'({start_calc, {UNIT_SHIFT{1'b0}}});
              left_r  <= cur_r.need;
              state_r <= S_MARK;
            end else if (idx_r == UNIT_W'(NUM_UNITS - 1)) begin
              status_r <= ST_NO_RUN;
              state_r  <= S_RES;
            end
          end else begin
            run_r <= '0;
            if (idx_r == UNIT_W'(NUM_UNITS - 1)) begin
              status_r <= ST_NO_RUN;
              state_r  <= S_RES;
            end
          end
        end
        S_MARK: begin
          busy_r[start_r] <= 1'b1;
          start_r <= start_r + UNIT_W'(1);
          left_r  <= left_r - CNT_W'(1);
          if (left_r == CNT_W'(1)) begin
            free_count_r <= free_count_r - cur_r.need;
            next_id_r    <= (next_id_r == ID_MAX) ? ID_W'(1) : next_id_r + ID_W'(1);
            status_r     <= ST_OK;
            state_r      <= S_RES;
          end
        end
        S_FID: begin
          id_r       <= rd_data_r;
          idx_r      <= '0;
          chk_vld_r  <= 1'b0;
          iss_done_r <= 1'b0;
          state_r    <= S_SWEEP;
        end
        S_SWEEP: begin
          if (!iss_done_r) begin
            idx_r     <= idx_r + UNIT_W'(1);
            chk_idx_r <= idx_r;
            chk_vld_r <= 1'b1;
            if (idx_r == UNIT_W'(NUM_UNITS - 1)) iss_done_r <= 1'b1;
          end else begin
            chk_vld_r <= 1'b0;
          end
          if (hit) begin
            busy_r[chk_idx_r] <= 1'b0;
            free_count_r      <= free_count_r + CNT_W'(1);
          end
          if (chk_vld_r && chk_idx_r == UNIT_W'(NUM_UNITS - 1)) begin
            status_r <= ST_OK;
            state_r  <= S_RES;
          end
        end
        S_RES: begin
          if (!rq_full) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[src/contiguous_block_allocator_top.sv]
// First-fit contiguous block allocator, top level. Uses cba_pkg, cba_front, cba_back.
// A bad request goes straight to a result; allocate scans up to 128 units first-fit,
// then marks the run; free sweeps all 128 owner entries at one read a cycle.
// One request at a time; two requests and two results can queue.
// Reset (rst_n, synchronous, active low) frees every unit at once via per-unit busy
// flags, sets next id to 1 and the free count to 128; no clearing pass is needed.
module contiguous_block_allocator_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  cba_pkg::cba_in_t  in_req,
  output logic              out_empty,
  input  logic              out_pop,
  output cba_pkg::cba_out_t out_res
);
  import cba_pkg::*;

  logic     cq_valid, cq_pop;
  cba_cmd_t cq_head;

  cba_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_req   (in_req),
    .cq_valid (cq_valid),
    .cq_head  (cq_head),
    .cq_pop   (cq_pop)
  );

  cba_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cq_valid  (cq_valid),
    .cq_head   (cq_head),
    .cq_pop    (cq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

  a_err_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_res.status != ST_OK) |-> (out_res.address == '0))
    else $error("error result with nonzero address");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_res.free_units <= CNT_W'(NUM_UNITS)))
    else $error("free unit count beyond heap");

  a_reset_clean: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule

[tb/tb_contiguous_block_allocator_top.sv]
// Self-checking testbench for contiguous_block_allocator_top: directed and random
// allocate/free requests, each result checked against a first-fit heap predictor.
// Depends on cba_pkg and the allocator RTL.
module tb_contiguous_block_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cba_pkg::*;

  localparam int RANDOM_REQS = 1675;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 1000;
  localparam int PAUSE_AT    = 900;

  class alloc_checker;
    logic [ID_W-1:0] owner [NUM_UNITS];
    logic [ID_W-1:0] next_id;
    int              free_cnt;
    cba_out_t        pending_results [$];
    int              errors;

    function new();
      foreach (owner[i]) owner[i] = '0;
      next_id  = 1;
      free_cnt = NUM_UNITS;
      errors   = 0;
    endfunction

    function cba_out_t apply_request(cba_in_t r);
      cba_out_t        res;
      int              need, run, start, idx;
      bit              found;
      logic [ID_W-1:0] id;
      res.address = '0;
      res.status  = ST_OK;
      if (r.cmd == CMD_ALLOC) begin
        if (r.size_bytes == 0 || (HEAP_BYTES % int'(r.size_bytes)) != 0) begin
          res.status = ST_BAD_SIZE;
        end else if (free_cnt == 0) begin
          res.status = ST_FULL;
        end else begin
          need  = (int'(r.size_bytes) + UNIT_BYTES - 1) / UNIT_BYTES;
          run   = 0;
          start = 0;
          found = 1'b0;
          for (int i = 0; i < NUM_UNITS; i++) begin
            if (owner[i] == '0) begin
              run++;
              if (run == need) begin
                start = i + 1 - need;
                found = 1'b1;
                break;
              end
            end else begin
              run = 0;
            end
          end
          if (!found) begin
            res.status = ST_NO_RUN;
          end else begin
            for (int k = 0; k < need; k++) owner[start + k] = next_id;
            free_cnt -= need;
            next_id = (next_id == ID_MAX) ? ID_W'(1) : next_id + 1'b1;
            res.address = ADDR_W'(start * UNIT_BYTES);
          end
        end
      end else begin
        idx = int'(r.offset) / UNIT_BYTES;
        if (int'(r.offset) >= HEAP_BYTES || owner[idx] == '0) begin
          res.status = ST_BAD_FREE;
        end else begin
          id = owner[idx];
          for (int i = 0; i < NUM_UNITS; i++) begin
            if (owner[i] == id) begin
              owner[i] = '0;
              free_cnt++;
            end
          end
        end
      end
      res.free_units = CNT_W'(free_cnt);
      return res;
    endfunction

    function void note_request(cba_in_t r);
      pending_results.push_back(apply_request(r));
    endfunction

    function void check_result(cba_out_t got);
      cba_out_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: address %0d status %0d free_units %0d",
                 $time, got.address, got.status, got.free_units);
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (got.address !== exp_res.address) begin
        $display("%0t: address expected %0d actual %0d", $time, exp_res.address, got.address);
        errors++;
      end
      if (got.status !== exp_res.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_res.status, got.status);
        errors++;
      end
      if (got.free_units !== exp_res.free_units) begin
        $display("%0t: free_units expected %0d actual %0d",
                 $time, exp_res.free_units, got.free_units);
        errors++;
      end
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_push   = 1'b0;
  logic     in_full;
  cba_in_t  in_req    = '0;
  logic     out_empty;
  logic     out_pop   = 1'b0;
  cba_out_t out_res;

  alloc_checker sb = new();

  contiguous_block_allocator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_req    (in_req),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic cba_in_t mk_req(logic cmd, int size, int off);
    cba_in_t r;
    r.cmd        = cmd;
    r.size_bytes = SIZE_W'(size);
    r.offset     = ADDR_W'(off);
    return r;
  endfunction

  // Unused fields carry random bits too. Id wrap-around needs 64k allocations
  // and is out of reach of a run this length.
  function automatic cba_in_t next_request(bit fill_phase);
    cba_in_t r;
    int      p, idx;
    r.cmd        = CMD_FREE;
    r.size_bytes = SIZE_W'($urandom_range(0, 2047));
    r.offset     = ADDR_W'($urandom_range(0, 1023));
    p = $urandom_range(0, 99);
    if (p < (fill_phase ? 75 : 40)) begin
      r.cmd = CMD_ALLOC;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: r.size_bytes = SIZE_W'(1 << $urandom_range(0, 6));
        6, 7:             r.size_bytes = SIZE_W'(1 << $urandom_range(7, 10));
        8:                r.size_bytes = SIZE_W'($urandom_range(0, HEAP_BYTES));
        default: ;
      endcase
    end else if (p < 95) begin
      repeat (8) begin
        idx = $urandom_range(0, NUM_UNITS - 1);
        if (sb.owner[idx] != '0) begin
          r.offset = ADDR_W'(idx * UNIT_BYTES + $urandom_range(0, UNIT_BYTES - 1));
          break;
        end
      end
    end
    return r;
  endfunction

  task automatic send_request(cba_in_t r, int gap);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_req  <= r;
    do @(posedge clk); while (in_full);
    sb.note_request(r);
  endtask

  function automatic int sender_gap(int n);
    return ((n / 100) % 4 == 3) ? 0 : $urandom_range(0, 5);
  endfunction

  initial begin
    cba_in_t directed [$];
    int      n;
    directed.push_back(mk_req(CMD_ALLOC, 0, 0));
    directed.push_back(mk_req(CMD_ALLOC, 3, 0));
    directed.push_back(mk_req(CMD_ALLOC, 2047, 0));
    directed.push_back(mk_req(CMD_ALLOC, 1536, 0));
    directed.push_back(mk_req(CMD_FREE, 0, 0));
    directed.push_back(mk_req(CMD_FREE, 0, 1023));
    directed.push_back(mk_req(CMD_ALLOC, 1, 0));
    directed.push_back(mk_req(CMD_ALLOC, 4, 0));
    directed.push_back(mk_req(CMD_ALLOC, 16, 0));
    directed.push_back(mk_req(CMD_FREE, 0, 23));
    directed.push_back(mk_req(CMD_ALLOC, 1024, 0));
    directed.push_back(mk_req(CMD_FREE, 0, 0));
    directed.push_back(mk_req(CMD_FREE, 0, 8));
    directed.push_back(mk_req(CMD_ALLOC, 1024, 0));
    directed.push_back(mk_req(CMD_ALLOC, 8, 0));
    directed.push_back(mk_req(CMD_FREE, 0, 1023));
    directed.push_back(mk_req(CMD_ALLOC, 512, 0));
    directed.push_back(mk_req(CMD_ALLOC, 256, 0));
    directed.push_back(mk_req(CMD_ALLOC, 128, 0));
    directed.push_back(mk_req(CMD_ALLOC, 64, 0));
    directed.push_back(mk_req(CMD_FREE, 0, 600));
    directed.push_back(mk_req(CMD_ALLOC, 512, 0));
    directed.push_back(mk_req(CMD_ALLOC, 256, 0));
    directed.push_back(mk_req(CMD_ALLOC, 64, 0));
    directed.push_back(mk_req(CMD_ALLOC, 2, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_request(directed[i], $urandom_range(0, 5));

    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n == PAUSE_AT) begin
        in_push <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
      end
      send_request(next_request((n / 150) % 2 == 0), sender_gap(n));
    end
    in_push <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("contiguous_block_allocator_top test passed");
    end else begin
      $display("contiguous_block_allocator_top test failed");
    end
    $finish;
  end

  // Result side; one long hold lets the request queue fill and push back.
  initial begin
    int popped;
    int gap;
    popped = 0;
    wait (rst_n);
    forever begin
      gap = ((popped / 90) % 4 == 1) ? 0 : $urandom_range(0, 5);
      if (popped == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      sb.check_result(out_res);
      popped++;
    end
  end

  initial begin
    #10_000_000;
    $display("contiguous_block_allocator_top test failed");
    $finish;
  end

endmodule
